### rtl/blr_pkg.sv
package blr_pkg;

   localparam int COORD_W = 8;
   localparam int COLOR_W = 16;
   localparam int INDEX_W = 14;
   localparam int ERROR_W = 10;

   localparam logic ACTION_START = 1'b0;
   localparam logic ACTION_STEP  = 1'b1;

   localparam logic [COLOR_W-1:0] DRAW_COLOR_RESET = 16'hFFFF;

   typedef logic [COORD_W-1:0] coord_type;
   typedef logic [COLOR_W-1:0] color_type;
   typedef logic [INDEX_W-1:0] index_type;
   typedef logic signed [ERROR_W-1:0] error_type;

   typedef struct packed {
      coord_type x;
      coord_type y;
      color_type color;
      logic      on_screen;
      index_type index;
      logic      last;
   } pixel_type;

endpackage

### rtl/bresenham_line_rasterizer_unit.sv
// Channel   Direction  Handshake              Payload
// req_      in         req_valid / req_stall  action, start_x/y, end_x/y
// rsp_      out        rsp_valid / rsp_stall  pixel x/y, color, on_screen, index, last
// csr_      in         csr_write_enable       csr_write_data (draw color)
//
// One item per cycle while req_stall is low; a pixel is registered at its transfer.
// The line state updates at the request transfer; a two-entry output
// (result register plus skid register) lets a request in while a pixel waits.
// req_stall rises only when both output entries are full.
// Synchronous reset clears the line state and sets draw color to all ones.
module bresenham_line_rasterizer_unit #(
   parameter int PANEL_WIDTH  = 128,
   parameter int PANEL_HEIGHT = 128
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_action,
   input  blr_pkg::coord_type req_start_x,
   input  blr_pkg::coord_type req_start_y,
   input  blr_pkg::coord_type req_end_x,
   input  blr_pkg::coord_type req_end_y,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output blr_pkg::coord_type rsp_pixel_x,
   output blr_pkg::coord_type rsp_pixel_y,
   output blr_pkg::color_type rsp_pixel_color,
   output logic               rsp_on_screen,
   output blr_pkg::index_type rsp_buffer_index,
   output logic               rsp_last,
   input  logic               csr_write_enable,
   input  blr_pkg::color_type csr_write_data
);
   import blr_pkg::*;

   localparam int WIDE_W = ERROR_W + 1;

   color_type draw_color_ff;
   coord_type cur_x_ff, cur_y_ff, target_x_ff, target_y_ff, span_x_ff, span_y_ff;
   coord_type cur_x_in, cur_y_in, target_x_in, target_y_in, span_x_in, span_y_in;
   logic      step_x_neg_ff, step_y_neg_ff, running_ff;
   logic      step_x_neg_in, step_y_neg_in, running_in;
   error_type error_ff, error_in;

   pixel_type main_ff, main_in, skid_ff, skid_in, new_pixel;
   logic      main_valid_ff, main_valid_in, skid_valid_ff, skid_valid_in;

   logic               accept, new_valid, main_take, new_last;
   coord_type          emit_x, emit_y;
   logic signed [WIDE_W-1:0] twice, wide_span_x, wide_span_y, err_sum;
   logic               move_x, move_y;

   assign req_stall = skid_valid_ff;
   assign accept    = req_valid && !req_stall;

   assign twice       = {error_ff, 1'b0};
   assign wide_span_x = $signed({3'b000, span_x_ff});
   assign wide_span_y = $signed({3'b000, span_y_ff});
   assign move_x      = twice > -wide_span_y;
   assign move_y      = twice < wide_span_x;

   always_comb begin
      cur_x_in      = cur_x_ff;
      cur_y_in      = cur_y_ff;
      target_x_in   = target_x_ff;
      target_y_in   = target_y_ff;
      span_x_in     = span_x_ff;
      span_y_in     = span_y_ff;
      step_x_neg_in = step_x_neg_ff;
      step_y_neg_in = step_y_neg_ff;
      error_in      = error_ff;
      running_in    = running_ff;
      new_valid     = 1'b0;
      new_last      = 1'b0;
      emit_x        = cur_x_ff;
      emit_y        = cur_y_ff;
      err_sum       = WIDE_W'(error_ff);
      if (accept) begin
         unique case (req_action)
            ACTION_START: begin
               cur_x_in      = req_start_x;
               cur_y_in      = req_start_y;
               target_x_in   = req_end_x;
               target_y_in   = req_end_y;
               span_x_in     = (req_start_x > req_end_x) ? req_start_x - req_end_x
                                                         : req_end_x - req_start_x;
               span_y_in     = (req_start_y > req_end_y) ? req_start_y - req_end_y
                                                         : req_end_y - req_start_y;
               step_x_neg_in = !(req_start_x < req_end_x);
               step_y_neg_in = !(req_start_y < req_end_y);
               error_in      = ERROR_W'($signed({2'b00, span_x_in}) - $signed({2'b00, span_y_in}));
               running_in    = (req_start_x != req_end_x) || (req_start_y != req_end_y);
               new_valid     = 1'b1;
               new_last      = !running_in;
               emit_x        = req_end_x;
               emit_y        = req_end_y;
            end
            ACTION_STEP: begin
               if (running_ff) begin
                  if (move_x) begin
                     err_sum  = err_sum - wide_span_y;
                     cur_x_in = step_x_neg_ff ? cur_x_ff - 8'd1 : cur_x_ff + 8'd1;
                  end
                  if (move_y) begin
                     err_sum  = err_sum + wide_span_x;
                     cur_y_in = step_y_neg_ff ? cur_y_ff - 8'd1 : cur_y_ff + 8'd1;
                  end
                  error_in   = err_sum[ERROR_W-1:0];
                  new_last   = (cur_x_in == target_x_ff) && (cur_y_in == target_y_ff);
                  running_in = !new_last;
                  new_valid  = 1'b1;
               end
            end
            default: begin
            end
         endcase
      end
   end

   blr_pixel_gen #(
      .PANEL_WIDTH  (PANEL_WIDTH),
      .PANEL_HEIGHT (PANEL_HEIGHT)
   ) u_pixel_gen (
      .x     (emit_x),
      .y     (emit_y),
      .color (draw_color_ff),
      .last  (new_last),
      .pixel (new_pixel)
   );

   // result register plus skid entry
   assign main_take = !main_valid_ff || !rsp_stall;

   always_comb begin
      main_in       = main_ff;
      main_valid_in = main_valid_ff;
      skid_in       = skid_ff;
      skid_valid_in = skid_valid_ff;
      if (main_take) begin
         if (skid_valid_ff) begin
            main_in       = skid_ff;
            main_valid_in = 1'b1;
            skid_valid_in = 1'b0;
         end else begin
            main_in       = new_pixel;
            main_valid_in = new_valid;
         end
      end else if (new_valid) begin
         skid_in       = new_pixel;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         draw_color_ff <= DRAW_COLOR_RESET;
         cur_x_ff      <= '0;
         cur_y_ff      <= '0;
         target_x_ff   <= '0;
         target_y_ff   <= '0;
         span_x_ff     <= '0;
         span_y_ff     <= '0;
         step_x_neg_ff <= 1'b0;
         step_y_neg_ff <= 1'b0;
         error_ff      <= '0;
         running_ff    <= 1'b0;
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            draw_color_ff <= csr_write_data;
         end
         cur_x_ff      <= cur_x_in;
         cur_y_ff      <= cur_y_in;
         target_x_ff   <= target_x_in;
         target_y_ff   <= target_y_in;
         span_x_ff     <= span_x_in;
         span_y_ff     <= span_y_in;
         step_x_neg_ff <= step_x_neg_in;
         step_y_neg_ff <= step_y_neg_in;
         error_ff      <= error_in;
         running_ff    <= running_in;
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid        = main_valid_ff;
   assign rsp_pixel_x      = main_ff.x;
   assign rsp_pixel_y      = main_ff.y;
   assign rsp_pixel_color  = main_ff.color;
   assign rsp_on_screen    = main_ff.on_screen;
   assign rsp_buffer_index = main_ff.index;
   assign rsp_last         = main_ff.last;

endmodule

### rtl/blr_pixel_gen.sv
module blr_pixel_gen #(
   parameter int PANEL_WIDTH  = 128,
   parameter int PANEL_HEIGHT = 128
) (
   input  blr_pkg::coord_type x,
   input  blr_pkg::coord_type y,
   input  blr_pkg::color_type color,
   input  logic               last,
   output blr_pkg::pixel_type pixel
);
   import blr_pkg::*;

   localparam int LIM_W  = COORD_W + 1;
   localparam int PROD_W = 2 * COORD_W + 1;

   logic              visible;
   logic [PROD_W-1:0] linear;

   assign visible = ({1'b0, x} < LIM_W'(PANEL_WIDTH)) && ({1'b0, y} < LIM_W'(PANEL_HEIGHT));
   assign linear  = PROD_W'(y) * PROD_W'(PANEL_WIDTH) + PROD_W'(x);

   always_comb begin
      pixel.x         = x;
      pixel.y         = y;
      pixel.color     = color;
      pixel.on_screen = visible;
      pixel.index     = visible ? linear[INDEX_W-1:0] : '0;
      pixel.last      = last;
   end

endmodule

### bench/tb.sv
module tb;
   import blr_pkg::*;

   localparam int PANEL_WIDTH  = 128;
   localparam int PANEL_HEIGHT = 128;

   class line_tracker;
      color_type color_q;
      coord_type cur_x, cur_y, dest_x, dest_y, span_x, span_y;
      logic      neg_x, neg_y, busy;
      error_type err_q;
      pixel_type expected_pixels[$];
      int        errors;

      function new();
         color_q = DRAW_COLOR_RESET;
         cur_x = '0; cur_y = '0; dest_x = '0; dest_y = '0;
         span_x = '0; span_y = '0;
         neg_x = 1'b0; neg_y = 1'b0; busy = 1'b0;
         err_q = '0;
         errors = 0;
      endfunction

      function int pending();
         return expected_pixels.size();
      endfunction

      function pixel_type make_pixel(coord_type x, coord_type y, logic is_last);
         pixel_type p;
         p.x = x;
         p.y = y;
         p.color = color_q;
         p.on_screen = (int'(x) < PANEL_WIDTH) && (int'(y) < PANEL_HEIGHT);
         p.index = p.on_screen ? index_type'(int'(y) * PANEL_WIDTH + int'(x)) : '0;
         p.last = is_last;
         return p;
      endfunction

      function void trace_request(logic act, coord_type sx, coord_type sy,
                                  coord_type ex, coord_type ey);
         int twice, nerr;
         if (act == ACTION_START) begin
            cur_x = sx; cur_y = sy; dest_x = ex; dest_y = ey;
            span_x = (sx > ex) ? sx - ex : ex - sx;
            span_y = (sy > ey) ? sy - ey : ey - sy;
            neg_x = !(sx < ex);
            neg_y = !(sy < ey);
            err_q = error_type'(int'(span_x) - int'(span_y));
            busy = (sx != ex) || (sy != ey);
            expected_pixels.push_back(make_pixel(ex, ey, !busy));
         end else if (busy) begin
            pixel_type p;
            p = make_pixel(cur_x, cur_y, 1'b0);
            twice = 2 * int'(err_q);
            nerr = int'(err_q);
            if (twice > -int'(span_y)) begin
               nerr -= int'(span_y);
               cur_x = neg_x ? cur_x - 8'd1 : cur_x + 8'd1;
            end
            if (twice < int'(span_x)) begin
               nerr += int'(span_x);
               cur_y = neg_y ? cur_y - 8'd1 : cur_y + 8'd1;
            end
            err_q = error_type'(nerr);
            if (cur_x == dest_x && cur_y == dest_y) busy = 1'b0;
            p.last = !busy;
            expected_pixels.push_back(p);
         end
      endfunction

      task report_mismatch(string what, int got, int want);
         $display("%0t mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
         errors++;
      endtask

      task check_pixel(pixel_type got);
         pixel_type want;
         if (expected_pixels.size() == 0) begin
            report_mismatch("unexpected pixel x", int'(got.x), 0);
         end else begin
            want = expected_pixels.pop_front();
            if (got.x !== want.x) report_mismatch("pixel_x", int'(got.x), int'(want.x));
            if (got.y !== want.y) report_mismatch("pixel_y", int'(got.y), int'(want.y));
            if (got.color !== want.color)
               report_mismatch("pixel_color", int'(got.color), int'(want.color));
            if (got.on_screen !== want.on_screen)
               report_mismatch("on_screen", int'(got.on_screen), int'(want.on_screen));
            if (got.index !== want.index)
               report_mismatch("buffer_index", int'(got.index), int'(want.index));
            if (got.last !== want.last)
               report_mismatch("last", int'(got.last), int'(want.last));
         end
      endtask
   endclass

   logic      clock = 1'b0;
   logic      reset = 1'b1;
   logic      req_valid = 1'b0;
   logic      req_stall;
   logic      req_action = ACTION_START;
   coord_type req_start_x = '0, req_start_y = '0, req_end_x = '0, req_end_y = '0;
   logic      rsp_valid;
   logic      rsp_stall = 1'b0;
   coord_type rsp_pixel_x, rsp_pixel_y;
   color_type rsp_pixel_color;
   logic      rsp_on_screen;
   index_type rsp_buffer_index;
   logic      rsp_last;
   logic      csr_write_enable = 1'b0;
   color_type csr_write_data = '0;

   line_tracker book = new();
   int send_idle_pct = 0;
   int stall_pct = 0;
   int items_sent = 0;

   bresenham_line_rasterizer_unit #(
      .PANEL_WIDTH (PANEL_WIDTH),
      .PANEL_HEIGHT(PANEL_HEIGHT)
   ) u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_action      (req_action),
      .req_start_x     (req_start_x),
      .req_start_y     (req_start_y),
      .req_end_x       (req_end_x),
      .req_end_y       (req_end_y),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_pixel_x     (rsp_pixel_x),
      .rsp_pixel_y     (rsp_pixel_y),
      .rsp_pixel_color (rsp_pixel_color),
      .rsp_on_screen   (rsp_on_screen),
      .rsp_buffer_index(rsp_buffer_index),
      .rsp_last        (rsp_last),
      .csr_write_enable(csr_write_enable),
      .csr_write_data  (csr_write_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   // transfer monitor: older pixels are checked before the new request is traced
   always @(posedge clock) begin
      pixel_type seen;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            seen.x = rsp_pixel_x;
            seen.y = rsp_pixel_y;
            seen.color = rsp_pixel_color;
            seen.on_screen = rsp_on_screen;
            seen.index = rsp_buffer_index;
            seen.last = rsp_last;
            book.check_pixel(seen);
         end
         if (req_valid && !req_stall)
            book.trace_request(req_action, req_start_x, req_start_y, req_end_x, req_end_y);
      end
   end

   task automatic send_item(logic act, coord_type sx, coord_type sy,
                            coord_type ex, coord_type ey);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_action <= act;
      req_start_x <= sx;
      req_start_y <= sy;
      req_end_x <= ex;
      req_end_y <= ey;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   function automatic int line_steps(coord_type sx, coord_type sy, coord_type ex, coord_type ey);
      int dx, dy;
      dx = (sx > ex) ? sx - ex : ex - sx;
      dy = (sy > ey) ? sy - ey : ey - sy;
      return (dx > dy) ? dx : dy;
   endfunction

   // start plus a number of steps; steps past the end point are ignored by the block
   task automatic draw_line(coord_type sx, coord_type sy, coord_type ex, coord_type ey,
                            int steps);
      int len;
      len = line_steps(sx, sy, ex, ey);
      send_item(ACTION_START, sx, sy, ex, ey);
      for (int k = 0; k < steps; k++)
         send_item(ACTION_STEP, coord_type'($urandom), coord_type'($urandom),
                   coord_type'($urandom), coord_type'($urandom));
      items_sent += 1 + ((steps < len) ? steps : len);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (book.pending() != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_color(color_type c);
      csr_write_enable <= 1'b1;
      csr_write_data <= c;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      book.color_q = c;
   endtask

   function automatic coord_type near_coord(coord_type c);
      int v;
      v = int'(c) + $urandom_range(16) - 8;
      if (v < 0) v = 0;
      if (v > 255) v = 255;
      return coord_type'(v);
   endfunction

   task automatic random_lines(int quota);
      int goal, len, mode, n;
      coord_type sx, sy, ex, ey;
      goal = items_sent + quota;
      while (items_sent < goal) begin
         sx = coord_type'($urandom); sy = coord_type'($urandom);
         if ($urandom_range(99) < 5) begin
            ex = coord_type'($urandom); ey = coord_type'($urandom);
         end else begin
            ex = near_coord(sx); ey = near_coord(sy);
         end
         len = line_steps(sx, sy, ex, ey);
         mode = $urandom_range(99);
         if (mode < 75) begin
            draw_line(sx, sy, ex, ey, len);
         end else if (mode < 85) begin
            draw_line(sx, sy, ex, ey, $urandom_range(len));
         end else if (mode < 92) begin
            draw_line(sx, sy, ex, ey, len + $urandom_range(3, 1));
         end else begin
            n = $urandom_range(6, 2);
            for (int k = 0; k < n; k++) begin
               send_item(logic'($urandom_range(1)), coord_type'($urandom),
                         coord_type'($urandom), coord_type'($urandom),
                         coord_type'($urandom));
               items_sent++;
            end
         end
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed: idle step, single points, coordinate-range corners, axis lines, panel edge
      send_item(ACTION_STEP, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
      draw_line(8'd0, 8'd0, 8'd0, 8'd0, 1);
      draw_line(8'd255, 8'd255, 8'd255, 8'd255, 0);
      draw_line(8'd255, 8'd0, 8'd0, 8'd255, 3);
      draw_line(8'd0, 8'd255, 8'd255, 8'd0, 2);
      draw_line(8'd10, 8'd10, 8'd10, 8'd14, 5);
      draw_line(8'd20, 8'd5, 8'd17, 8'd5, 3);
      draw_line(8'd126, 8'd126, 8'd129, 8'd128, 3);

      drain();
      write_color(16'h0000);
      random_lines(100);

      drain();
      write_color(16'hFFFF);
      send_idle_pct = 53;
      random_lines(100);

      drain();
      write_color(color_type'($urandom));
      send_idle_pct = 0;
      stall_pct = 53;
      random_lines(100);

      drain();
      write_color(16'h5AA5);
      send_idle_pct = 14;
      stall_pct = 14;
      random_lines(100);

      drain();
      stall_pct = 0;
      repeat (8) @(posedge clock);
      if (book.pending() != 0) book.report_mismatch("pixels never seen", 0, book.pending());
      if (book.errors == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

   initial begin
      #2000000;
      $display("TEST FAILED");
      $finish;
   end

endmodule
